### src/float_matrix_multiply_4x4_macros.svh
// ---------------------------------------------------------------------------
// float_matrix_multiply_4x4_macros
// Assertion macros for the float matrix multiply block.
// ---------------------------------------------------------------------------
`ifndef FLOAT_MATRIX_MULTIPLY_4X4_MACROS_SVH
`define FLOAT_MATRIX_MULTIPLY_4X4_MACROS_SVH
`ifndef SYNTHESIS
`define FMM_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define FMM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define FMM_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define FMM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

### src/fmm_pkg.sv
// ---------------------------------------------------------------------------
// fmm_pkg
// Shared constants and pipeline types for the float matrix multiply.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package fmm_pkg;
    localparam logic        OP_LOAD   = 1'b0;
    localparam logic        OP_MULT   = 1'b1;
    localparam logic [31:0] QNAN_BITS = 32'h7FC0_0000;
    localparam int          NSTAGE    = 7;

    // Operand class flags computed by classify().
    typedef struct packed {
        logic nan;
        logic inf;
        logic zero;
    } fcls_t;

    function automatic fcls_t classify(input logic [31:0] x);
        fcls_t c;
        c.nan  = (x[30:23] == 8'hFF) && (x[22:0] != 23'd0);
        c.inf  = (x[30:0] == 31'h7F80_0000);
        c.zero = (x[30:0] == 31'd0);
        return c;
    endfunction

    // Round a normalized-or-subnormal magnitude: sig has bit 26 leading when
    // normal, 3 guard bits below a 24-bit significand field; e is biased,
    // below 1 for a subnormal result.
    // Returns packed result (sticky already in sig[0]).
    function automatic logic [31:0] round_fin(input logic s, input logic signed [10:0] e,
                                              input logic [26:0] sig);
        logic [24:0] mant;
        logic        rup;
        logic [7:0]  ebase;
        logic [31:0] r;
        rup   = sig[2] && (sig[1] || sig[0] || sig[3]);
        mant  = {1'b0, sig[26:3]} + {24'd0, rup};
        ebase = (e < 11'sd1) ? 8'd0 : (e[7:0] - 8'd1);
        // mant carry into bit 24 bumps the exponent through the add below
        if (e >= 11'sd255)
            r = {s, 8'hFF, 23'd0};
        else
            r = {s, 31'd0} + {1'b0, ebase, 23'd0} + {7'd0, mant};
        if (r[30:23] == 8'hFF) r = {s, 8'hFF, 23'd0};
        return r;
    endfunction
endpackage
`default_nettype wire

### src/fmm_fmul.sv
// ---------------------------------------------------------------------------
// fmm_fmul
// Two-stage binary32 multiplier: product register, then normalize and round.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module fmm_fmul
    import fmm_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        en,
    input  wire logic [31:0] a,
    input  wire logic [31:0] b,
    output logic      [31:0] p
);
    fcls_t              ca, cb;
    logic [47:0]        prod_reg, prod_next;
    logic signed [10:0] exp_reg, exp_next;
    logic               sign_reg, spec_reg, spec_next;
    logic [31:0]        sval_reg, sval_next;
    logic [31:0]        p_reg, p_next;

    always_comb
    begin
        ca = classify(a);
        cb = classify(b);
        prod_next = {24'd0, (a[30:23] != 8'd0), a[22:0]} * {24'd0, (b[30:23] != 8'd0), b[22:0]};
        // value = prod * 2^(exp-127-47) with exp = ea+eb-126 in product-scale
        exp_next = $signed({3'd0, ((a[30:23] == 8'd0) ? 8'd1 : a[30:23])})
                 + $signed({3'd0, ((b[30:23] == 8'd0) ? 8'd1 : b[30:23])}) - 11'sd126;
        spec_next = 1'b1;
        if (ca.nan || cb.nan || (ca.inf && cb.zero) || (cb.inf && ca.zero))
            sval_next = QNAN_BITS;
        else if (ca.inf || cb.inf)
            sval_next = {a[31] ^ b[31], 8'hFF, 23'd0};
        else if (ca.zero || cb.zero)
            sval_next = {a[31] ^ b[31], 31'd0};
        else
        begin
            spec_next = 1'b0;
            sval_next = 32'd0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= prod_next;
            exp_reg  <= exp_next;
            sign_reg <= a[31] ^ b[31];
            spec_reg <= spec_next;
            sval_reg <= sval_next;
        end
    end

    // Leading-one position: prod has leading bit at 47 or below.
    logic [5:0]         lz;
    logic [47:0]        nrm;
    logic signed [10:0] en_exp;
    logic [5:0]         rsh;
    logic [47:0]        sh;
    logic               stk;
    logic [26:0]        sig;

    always_comb
    begin
        lz = 6'd0;
        for (int i = 0; i < 48; i++)
            if (prod_reg[i]) lz = 6'(47 - i);
        nrm    = prod_reg << lz;
        en_exp = exp_reg - $signed({5'd0, lz});
        rsh    = 6'd0;
        if (en_exp < 11'sd1)
            rsh = (en_exp < -11'sd40) ? 6'd41 : 6'(11'sd1 - en_exp);
        sh  = nrm >> rsh;
        stk = ((nrm & ((48'd1 << rsh) - 48'd1)) != 48'd0) || (sh[21:0] != 22'd0);
        sig = {sh[47:22], stk};
        if (spec_reg)
            p_next = sval_reg;
        else if (sh[47])
            p_next = round_fin(sign_reg, (rsh != 6'd0) ? 11'sd1 : en_exp, sig);
        else
            p_next = round_fin(sign_reg, 11'sd0, sig);
    end

    always_ff @(posedge clk)
    begin
        if (en) p_reg <= p_next;
    end
    assign p = p_reg;
endmodule
`default_nettype wire

### src/fmm_fadd.sv
// ---------------------------------------------------------------------------
// fmm_fadd
// Two-stage binary32 adder: align and add, then normalize and round.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module fmm_fadd
    import fmm_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        en,
    input  wire logic [31:0] a,
    input  wire logic [31:0] b,
    output logic      [31:0] s
);
    fcls_t       ca, cb;
    logic [31:0] x, y;
    logic [7:0]  ex, ey, d;
    logic [26:0] mx, my, mys;
    logic [27:0] sum_next, sum_reg;
    logic [7:0]  exp_reg;
    logic        sgn_reg, spec_reg, spec_next;
    logic [31:0] sval_reg, sval_next, s_reg, s_next;

    always_comb
    begin
        ca = classify(a);
        cb = classify(b);
        if (b[30:0] > a[30:0])
        begin
            x = b;
            y = a;
        end
        else
        begin
            x = a;
            y = b;
        end
        ex  = (x[30:23] == 8'd0) ? 8'd1 : x[30:23];
        ey  = (y[30:23] == 8'd0) ? 8'd1 : y[30:23];
        mx  = {(x[30:23] != 8'd0), x[22:0], 3'd0};
        my  = {(y[30:23] != 8'd0), y[22:0], 3'd0};
        d   = ex - ey;
        mys = (d > 8'd26) ? {26'd0, (my != 27'd0)}
                          : ((my >> d) | {26'd0, ((my & ((27'd1 << d) - 27'd1)) != 27'd0)});
        sum_next = (x[31] == y[31]) ? ({1'b0, mx} + {1'b0, mys}) : ({1'b0, mx} - {1'b0, mys});
        spec_next = 1'b1;
        if (ca.nan || cb.nan || (ca.inf && cb.inf && (a[31] != b[31])))
            sval_next = QNAN_BITS;
        else if (ca.inf)
            sval_next = a;
        else if (cb.inf)
            sval_next = b;
        else if (ca.zero && cb.zero)
            sval_next = {a[31] & b[31], 31'd0};
        else if (ca.zero)
            sval_next = b;
        else if (cb.zero)
            sval_next = a;
        else if (sum_next == 28'd0)
            sval_next = 32'd0;
        else
        begin
            spec_next = 1'b0;
            sval_next = 32'd0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sum_reg  <= sum_next;
            exp_reg  <= ex;
            sgn_reg  <= x[31];
            spec_reg <= spec_next;
            sval_reg <= sval_next;
        end
    end

    logic [4:0]         lz;
    logic signed [10:0] ne;
    logic [4:0]         sh;
    logic [26:0]        sig;

    always_comb
    begin
        lz = 5'd0;
        for (int i = 0; i < 27; i++)
            if (sum_reg[i]) lz = 5'(26 - i);
        sig = 27'd0;
        ne  = 11'sd0;
        sh  = 5'd0;
        if (sum_reg[27])
        begin
            sig = sum_reg[27:1] | {26'd0, sum_reg[0]};
            ne  = $signed({3'd0, exp_reg}) + 11'sd1;
        end
        else
        begin
            // no left shift below exponent 1: keep subnormal
            sh  = ({3'd0, exp_reg} - 11'd1 < {6'd0, lz}) ? 5'(exp_reg - 8'd1) : lz;
            sig = sum_reg[26:0] << sh;
            ne  = $signed({3'd0, exp_reg}) - $signed({6'd0, sh});
            if (!sig[26]) ne = 11'sd0;
        end
        s_next = spec_reg ? sval_reg : round_fin(sgn_reg, ne, sig);
    end

    always_ff @(posedge clk)
    begin
        if (en) s_reg <= s_next;
    end
    assign s = s_reg;
endmodule
`default_nettype wire

### src/float_matrix_multiply_4x4.sv
// Throughput: one row per cycle while the output is not stalled; load rows write the B bank directly.
// The pipeline is multiply (2 stages), add (2), add (2), output register (1).
// Reset clears valid bits and the output valid; the B bank holds no reset value.
// A stall freezes every stage together.
`timescale 1ns / 1ps
`default_nettype none
`include "float_matrix_multiply_4x4_macros.svh"
// ---------------------------------------------------------------------------
// float_matrix_multiply_4x4
// Streams rows of A through a B bank set by load rows and returns rows of A*B.
// ---------------------------------------------------------------------------
module float_matrix_multiply_4x4
    import fmm_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        op,
    input  wire logic [1:0]  row_index,
    input  wire logic [31:0] elem0,
    input  wire logic [31:0] elem1,
    input  wire logic [31:0] elem2,
    input  wire logic [31:0] elem3,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [1:0]       out_row,
    output logic [31:0]      prod0,
    output logic [31:0]      prod1,
    output logic [31:0]      prod2,
    output logic [31:0]      prod3
);
    logic [31:0] bank_reg [16];
    logic [31:0] arow [4];
    logic        en;
    logic [NSTAGE-1:0] vld_reg, vld_next;
    logic [1:0]  row_reg [NSTAGE];

    // Whole pipe moves when the last slot is empty or being taken.
    assign en       = !vld_reg[NSTAGE-1] || out_ready;
    assign in_ready = en;
    assign arow[0]  = elem0;
    assign arow[1]  = elem1;
    assign arow[2]  = elem2;
    assign arow[3]  = elem3;

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready && (op == OP_LOAD))
            for (int j = 0; j < 4; j++)
                bank_reg[{row_index, 2'(j)}] <= arow[j];
    end

    always_comb
    begin
        vld_next = {vld_reg[NSTAGE-2:0], in_valid && (op == OP_MULT)};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= vld_next;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            row_reg[0] <= row_index;
            for (int i = 1; i < NSTAGE; i++)
                row_reg[i] <= row_reg[i-1];
        end
    end

    logic [31:0] pr  [4][4];
    logic [31:0] s01 [4];
    logic [31:0] s23 [4];
    logic [31:0] fin [4];
    logic [31:0] out_reg [4];

    for (genvar j = 0; j < 4; j++)
    begin : g_col
        for (genvar k = 0; k < 4; k++)
        begin : g_mul
            fmm_fmul u_mul (
                .clk (clk),
                .en  (en),
                .a   (arow[k]),
                .b   (bank_reg[4*k + j]),
                .p   (pr[j][k])
            );
        end
        fmm_fadd u_add01 (.clk(clk), .en(en), .a(pr[j][0]), .b(pr[j][1]), .s(s01[j]));
        fmm_fadd u_add23 (.clk(clk), .en(en), .a(pr[j][2]), .b(pr[j][3]), .s(s23[j]));
        fmm_fadd u_addf  (.clk(clk), .en(en), .a(s01[j]), .b(s23[j]), .s(fin[j]));
        always_ff @(posedge clk)
        begin
            if (en) out_reg[j] <= fin[j];
        end
    end

    assign out_valid = vld_reg[NSTAGE-1];
    assign out_row   = row_reg[NSTAGE-1];
    assign prod0     = out_reg[0];
    assign prod1     = out_reg[1];
    assign prod2     = out_reg[2];
    assign prod3     = out_reg[3];

    `FMM_ASSERT_NEXT(a_stall_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_row), "stalled result changed")
    `FMM_ASSERT_IMPL(a_ready_free, clk, rst_n, !out_valid, in_ready, "ready low with empty output")
    `FMM_ASSERT_NEXT(a_load_no_result, clk, rst_n, in_valid && in_ready && (op == OP_LOAD), !vld_reg[0], "load row entered pipe")
endmodule
`default_nettype wire

### tb/tb_float_matrix_multiply_4x4.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_float_matrix_multiply_4x4
// Loads the B bank and streams A rows through the block. Every product row
// is checked against a bit-exact binary32 predictor kept in a scoreboard,
// under random input gaps and output back-pressure.
// ---------------------------------------------------------------------------
module tb_float_matrix_multiply_4x4;
    import fmm_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int RANDOM_ITEMS   = 1130;
    localparam int LONG_HOLD      = 300;

    typedef struct {
        logic [1:0]  row;
        logic [31:0] p [4];
    } prod_row_t;

    // binary32 arithmetic, round to nearest even, subnormals kept
    function automatic bit f_nan(input logic [31:0] x);
        return (x[30:23] == 8'hFF) && (x[22:0] != 23'd0);
    endfunction

    function automatic bit f_inf(input logic [31:0] x);
        return x[30:0] == 31'h7F80_0000;
    endfunction

    function automatic bit f_zero(input logic [31:0] x);
        return x[30:0] == 31'd0;
    endfunction

    function automatic void split_f32(input logic [31:0] x, output int e,
                                      output bit [63:0] m);
        if (x[30:23] == 8'd0)
        begin
            e = 1;
            m = {41'd0, x[22:0]};
        end
        else
        begin
            e = int'(x[30:23]);
            m = {40'd0, 1'b1, x[22:0]};
        end
    endfunction

    function automatic bit [63:0] sticky_shr(input bit [63:0] v, input int n);
        if (n <= 0)
            return v;
        if (n >= 63)
            return (v != 0) ? 64'd1 : 64'd0;
        return (v >> n) | (((v & ((64'd1 << n) - 64'd1)) != 0) ? 64'd1 : 64'd0);
    endfunction

    // value = sig * 2^(e - 127 - 62)
    function automatic logic [31:0] pack_f32(input bit s, input int e, input bit [63:0] sig);
        bit [63:0] mant;
        bit [63:0] rem;
        bit [63:0] half;
        half = 64'd1 << 38;
        while (!sig[62])
        begin
            sig = sig << 1;
            e--;
        end
        if (e >= 255)
            return {s, 8'hFF, 23'd0};
        if (e <= 0)
        begin
            sig = sticky_shr(sig, 1 - e);
            e = 1;
        end
        mant = sig >> 39;
        rem  = sig & ((64'd1 << 39) - 64'd1);
        if (rem > half || (rem == half && mant[0]))
            mant++;
        return {s, 31'd0} + (32'(e - 1) << 23) + mant[31:0];
    endfunction

    function automatic logic [31:0] mul_f32(input logic [31:0] a, input logic [31:0] b);
        bit        s;
        int        ea;
        int        eb;
        bit [63:0] ma;
        bit [63:0] mb;
        s = a[31] ^ b[31];
        if (f_nan(a) || f_nan(b))
            return QNAN_BITS;
        if (f_inf(a) || f_inf(b))
        begin
            if (f_zero(a) || f_zero(b))
                return QNAN_BITS;
            return {s, 8'hFF, 23'd0};
        end
        if (f_zero(a) || f_zero(b))
            return {s, 31'd0};
        split_f32(a, ea, ma);
        split_f32(b, eb, mb);
        return pack_f32(s, ea + eb - 111, ma * mb);
    endfunction

    function automatic logic [31:0] add_f32(input logic [31:0] a, input logic [31:0] b);
        bit        sa;
        bit        sb;
        bit        st;
        int        ea;
        int        eb;
        int        et;
        bit [63:0] ma;
        bit [63:0] mb;
        bit [63:0] mt;
        bit [63:0] sum;
        sa = a[31];
        sb = b[31];
        if (f_nan(a) || f_nan(b))
            return QNAN_BITS;
        if (f_inf(a) && f_inf(b))
            return (sa == sb) ? a : QNAN_BITS;
        if (f_inf(a))
            return a;
        if (f_inf(b))
            return b;
        if (f_zero(a) && f_zero(b))
            return {sa & sb, 31'd0};
        if (f_zero(a))
            return b;
        if (f_zero(b))
            return a;
        split_f32(a, ea, ma);
        split_f32(b, eb, mb);
        ma = ma << 37;
        mb = mb << 37;
        if (eb > ea || (eb == ea && mb > ma))
        begin
            et = ea; ea = eb; eb = et;
            mt = ma; ma = mb; mb = mt;
            st = sa; sa = sb; sb = st;
        end
        mb = sticky_shr(mb, ea - eb);
        if (sa == sb)
            sum = ma + mb;
        else
        begin
            sum = ma - mb;
            if (sum == 0)
                return 32'd0;
        end
        return pack_f32(sa, ea + 2, sum);
    endfunction

    class product_scoreboard;
        logic [31:0] b_bank [16];
        prod_row_t   expected_rows [$];
        int          mismatches;
        int          rows_checked;
        int          loads_seen;
        int          special_rows;

        function void note_input(input logic o, input logic [1:0] r, input logic [31:0] a [4]);
            prod_row_t pr;
            if (o == OP_LOAD)
            begin
                for (int j = 0; j < 4; j++)
                    b_bank[r * 4 + j] = a[j];
                loads_seen++;
                return;
            end
            pr.row = r;
            for (int j = 0; j < 4; j++)
                pr.p[j] = add_f32(add_f32(mul_f32(a[0], b_bank[j]), mul_f32(a[1], b_bank[4 + j])),
                                  add_f32(mul_f32(a[2], b_bank[8 + j]),
                                          mul_f32(a[3], b_bank[12 + j])));
            expected_rows.push_back(pr);
        endfunction

        function void check_result(input logic [1:0] r, input logic [31:0] p [4]);
            prod_row_t pr;
            bit        bad;
            if (expected_rows.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected product row %0d at %0t", r, $realtime);
                return;
            end
            pr = expected_rows.pop_front();
            rows_checked++;
            bad = (r !== pr.row);
            for (int j = 0; j < 4; j++)
            begin
                if (p[j] !== pr.p[j])
                    bad = 1;
                if (pr.p[j][30:23] == 8'hFF)
                    special_rows++;
            end
            if (bad)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: row exp %0d %h %h %h %h, got %0d %h %h %h %h",
                             pr.row, pr.p[0], pr.p[1], pr.p[2], pr.p[3],
                             r, p[0], p[1], p[2], p[3]);
            end
        endfunction

        function int pending();
            return expected_rows.size();
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic        op;
    logic [1:0]  row_index;
    logic [31:0] elem0;
    logic [31:0] elem1;
    logic [31:0] elem2;
    logic [31:0] elem3;
    logic        out_valid;
    logic        out_ready;
    logic [1:0]  out_row;
    logic [31:0] prod0;
    logic [31:0] prod1;
    logic [31:0] prod2;
    logic [31:0] prod3;

    product_scoreboard sb;
    int burst_left;
    int idle_cycles;
    bit hold_req;
    int hold_cnt;
    int rx_mode;
    int phase_cnt;
    int rx_tick;

    float_matrix_multiply_4x4 uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .op        (op),
        .row_index (row_index),
        .elem0     (elem0),
        .elem1     (elem1),
        .elem2     (elem2),
        .elem3     (elem3),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_row   (out_row),
        .prod0     (prod0),
        .prod1     (prod1),
        .prod2     (prod2),
        .prod3     (prod3)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic logic [31:0] pick_f32();
        logic [31:0] specials [12];
        specials = '{32'h0000_0000, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000,
                     32'h7FC0_0001, 32'hFFFF_FFFF, 32'h0000_0001, 32'h007F_FFFF,
                     32'h0080_0000, 32'h7F7F_FFFF, 32'h3F80_0000, 32'hBF80_0000};
        case ($urandom_range(0, 9))
            0: return $urandom;
            1: return specials[$urandom_range(0, 11)];
            // tiny operands push products into the subnormal range
            2: return {1'($urandom), 8'($urandom_range(40, 80)), 23'($urandom)};
            3: return {1'($urandom), 8'($urandom_range(190, 254)), 23'($urandom)};
            default: return {1'($urandom), 8'($urandom_range(120, 134)), 23'($urandom)};
        endcase
    endfunction

    task automatic send_row(input logic o, input logic [1:0] r, input logic [31:0] a0,
                            input logic [31:0] a1, input logic [31:0] a2,
                            input logic [31:0] a3);
        logic [31:0] a [4];
        a = '{a0, a1, a2, a3};
        @(negedge clk);
        if (burst_left == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clk);
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        in_valid  <= 1'b1;
        op        <= o;
        row_index <= r;
        elem0     <= a0;
        elem1     <= a1;
        elem2     <= a2;
        elem3     <= a3;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_input(o, r, a);
    endtask

    task automatic wait_for_empty();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    // receiver: ready pattern in phases, plus a single long hold
    always @(negedge clk)
    begin
        if (hold_req)
        begin
            hold_req = 1'b0;
            hold_cnt = LONG_HOLD;
        end
        if (hold_cnt > 0)
        begin
            hold_cnt--;
            out_ready <= 1'b0;
        end
        else
        begin
            if (phase_cnt == 0)
            begin
                rx_mode   = $urandom_range(0, 3);
                phase_cnt = $urandom_range(16, 96);
            end
            phase_cnt--;
            rx_tick++;
            case (rx_mode)
                0: out_ready <= 1'b1;
                1: out_ready <= 1'($urandom);
                2: out_ready <= ($urandom_range(0, 3) == 0);
                default: out_ready <= (rx_tick % 4 != 0);
            endcase
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result(out_row, '{prod0, prod1, prod2, prod3});
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles = 0;
        else
        begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("ERROR: watchdog, no transaction for %0d cycles", idle_cycles);
                $display("** float_matrix_multiply_4x4: FAILED **");
                $finish;
            end
        end
    end

    initial
    begin
        logic [31:0] b_rows [4][4];
        sb          = new();
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        op          = OP_LOAD;
        row_index   = 2'd0;
        elem0       = 32'd0;
        elem1       = 32'd0;
        elem2       = 32'd0;
        elem3       = 32'd0;
        out_ready   = 1'b0;
        burst_left  = 0;
        idle_cycles = 0;
        hold_req    = 1'b0;
        hold_cnt    = 0;
        rx_mode     = 0;
        phase_cnt   = 0;
        rx_tick     = 0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;

        // B with infinities, NaN, zeros of both signs, subnormals and extremes
        send_row(OP_LOAD, 2'd0, 32'h7F80_0000, 32'h0000_0000, 32'h7FC0_1234, 32'h3F80_0000);
        send_row(OP_LOAD, 2'd1, 32'h8000_0000, 32'hFF80_0000, 32'h7F7F_FFFF, 32'h0000_0001);
        send_row(OP_LOAD, 2'd2, 32'h3F80_0000, 32'hBF80_0000, 32'h0080_0000, 32'h007F_FFFF);
        send_row(OP_LOAD, 2'd3, 32'h4000_0000, 32'hC000_0000, 32'h7F7F_FFFF, 32'hFF7F_FFFF);
        send_row(OP_MULT, 2'd0, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        send_row(OP_MULT, 2'd1, 32'h3F80_0000, 32'h3F80_0000, 32'h3F80_0000, 32'h3F80_0000);
        send_row(OP_MULT, 2'd2, 32'h0000_0000, 32'h0000_0000, 32'h3F80_0000, 32'h3F80_0000);
        send_row(OP_MULT, 2'd3, 32'h7F7F_FFFF, 32'h7F7F_FFFF, 32'h7F7F_FFFF, 32'h7F7F_FFFF);
        send_row(OP_MULT, 2'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_row(OP_MULT, 2'd1, 32'h0000_0001, 32'h8000_0001, 32'h0000_0001, 32'h0080_0000);
        send_row(OP_MULT, 2'd2, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        // finite B for cancellation, exact zero sums and overflow
        send_row(OP_LOAD, 2'd0, 32'h3F80_0000, 32'h4000_0000, 32'h8000_0000, 32'h3F80_0000);
        send_row(OP_LOAD, 2'd1, 32'hBF80_0000, 32'hC000_0000, 32'h8000_0000, 32'h7F7F_FFFF);
        send_row(OP_MULT, 2'd3, 32'h3F80_0000, 32'h3F80_0000, 32'h0000_0000, 32'h0000_0000);
        send_row(OP_MULT, 2'd0, 32'h3F80_0000, 32'h3F80_0000, 32'h8000_0000, 32'h8000_0000);
        send_row(OP_MULT, 2'd1, 32'h7F7F_FFFF, 32'h3F80_0000, 32'h7F7F_FFFF, 32'h7F7F_FFFF);
        send_row(OP_MULT, 2'd2, 32'h3F80_0001, 32'h3F80_0000, 32'h3380_0000, 32'h0000_0000);
        send_row(OP_MULT, 2'd3, 32'hFF7F_FFFF, 32'h7F7F_FFFF, 32'h4000_0000, 32'hC000_0000);
        wait_for_empty();

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i == 400)
                hold_req = 1'b1;
            if (i == 800)
                wait_for_empty();
            if ($urandom_range(0, 99) < 4)
            begin
                // fresh B matrix, all four rows loaded in turn
                for (int r = 0; r < 4; r++)
                    for (int c = 0; c < 4; c++)
                        b_rows[r][c] = pick_f32();
                for (int r = 0; r < 4; r++)
                    send_row(OP_LOAD, 2'(r), b_rows[r][0], b_rows[r][1],
                             b_rows[r][2], b_rows[r][3]);
                i += 3;
            end
            else if ($urandom_range(0, 99) < 10)
                send_row(OP_LOAD, 2'($urandom), pick_f32(), pick_f32(), pick_f32(), pick_f32());
            else
                send_row(OP_MULT, 2'($urandom), pick_f32(), pick_f32(), pick_f32(), pick_f32());
        end
        wait_for_empty();
        repeat (20) @(posedge clk);

        $display("Covered %0d B-row loads and %0d product rows checked bit-exact,",
                 sb.loads_seen, sb.rows_checked);
        $display("%0d product elements inf or NaN, %0d mismatches.",
                 sb.special_rows, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("** float_matrix_multiply_4x4: PASSED **");
        else
            $display("** float_matrix_multiply_4x4: FAILED **");
        $finish;
    end
endmodule

### sim.f
+incdir+src
src/fmm_pkg.sv
src/fmm_fmul.sv
src/fmm_fadd.sv
src/float_matrix_multiply_4x4.sv
tb/tb_float_matrix_multiply_4x4.sv
